/* sv/rlx_pkg.sv */
package rlx_pkg;

    localparam int LAGS        = 24;
    localparam int WORD_W      = 24;
    localparam int PTR_W       = 5;
    localparam int LUX_W       = 11;
    localparam int SEED_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] LONG_PTR_INIT  = 5'd23;
    localparam logic [PTR_W-1:0] SHORT_PTR_INIT = 5'd9;
    localparam logic [PTR_W-1:0] LAST_LAG       = 5'd23;

    localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'd314159265;
    localparam logic [15:0]       SCH_Q        = 16'd53668;
    localparam logic [15:0]       SCH_A        = 16'd40014;
    localparam logic [13:0]       SCH_R        = 14'd12211;
    localparam logic [31:0]       SCH_M        = 32'd2147483563;

    localparam logic [LUX_W-1:0] LUX_RESET  = 11'd223;
    localparam logic [LUX_W-1:0] LUX_LAGS   = 11'd24;

    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef struct packed {
        logic              is_seed;
        logic [SEED_W-1:0] seed;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } wr_t;

    function automatic logic [LUX_W-1:0] skip_from(input logic [LUX_W-1:0] lux);
        logic [LUX_W-1:0] res;
        res = (lux < LUX_LAGS) ? '0 : (lux - LUX_LAGS);
        return res;
    endfunction

endpackage

/* sv/rlx_req_if.sv */
interface rlx_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] seed;

    modport source (output valid, output req_type, output seed, input ready);
    modport sink (input valid, input req_type, input seed, output ready);
endinterface

/* sv/rlx_res_if.sv */
interface rlx_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

/* sv/rlx_ram.sv */
module rlx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* sv/rlx_front.sv */
module rlx_front (
    input  logic          clk,
    input  logic          rst_n,
    rlx_req_if.sink       req,
    output rlx_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);

    rlx_pkg::cmd_t                    q_mem_reg [rlx_pkg::QUEUE_DEPTH];
    logic [rlx_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [rlx_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [rlx_pkg::QCNT_W-1:0]       count_reg;
    logic [rlx_pkg::QCNT_W-1:0]       count_next;
    logic                             push;
    logic                             pop;
    rlx_pkg::cmd_t                    in_cmd;

    assign req.ready = (count_reg != rlx_pkg::QCNT_W'(rlx_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.is_seed = (req.req_type == rlx_pkg::REQ_SEED);
        in_cmd.seed    = req.seed;
        count_next     = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + rlx_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - rlx_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rlx_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rlx_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* sv/rlx_seed.sv */
module rlx_seed (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rlx_pkg::SEED_W-1:0]  seed_val,
    output rlx_pkg::wr_t                wr,
    output logic                        done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_CORR = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;

    // floor(x / Q) ~ (x * Recip) >> 47, low by at most one for 32-bit x
    localparam logic [63:0] RECIP_WIDE = (64'd1 << 47) / 64'(rlx_pkg::SCH_Q);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [rlx_pkg::PTR_W-1:0]  k_reg;
    logic [31:0]                x_reg;
    logic [63:0]                prod1_reg;
    logic [16:0]                qe_reg;
    logic [32:0]                prod2_reg;
    logic [16:0]                q_reg;
    logic [15:0]                r_reg;
    logic [30:0]                t1_reg;
    logic [30:0]                t2_reg;

    logic [32:0]                rem_raw;
    logic [16:0]                rem17;
    logic [16:0]                rem_fix;
    logic [16:0]                q_fix;
    logic [32:0]                acc;
    logic [32:0]                acc_fix;

    always_comb
    begin
        rem_raw = 33'(x_reg) - prod2_reg;
        rem17   = rem_raw[16:0];
        rem_fix = rem17;
        q_fix   = qe_reg;
        if (rem17 >= 17'(rlx_pkg::SCH_Q))
        begin
            rem_fix = rem17 - 17'(rlx_pkg::SCH_Q);
            q_fix   = qe_reg + 17'd1;
        end
        acc     = 33'(t1_reg) - 33'(t2_reg);
        acc_fix = acc[32] ? (acc + 33'(rlx_pkg::SCH_M)) : acc;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_CORR;
            S_CORR: state_next = S_MUL3;
            S_MUL3: state_next = S_ACC;
            S_ACC:  state_next = (k_reg == rlx_pkg::LAST_LAG) ? S_IDLE : S_MUL1;
            default: state_next = S_IDLE;
        endcase
    end

    assign wr.en   = (state_reg == S_ACC);
    assign wr.addr = k_reg;
    assign wr.data = acc_fix[rlx_pkg::WORD_W-1:0];
    assign done    = (state_reg == S_ACC) && (k_reg == rlx_pkg::LAST_LAG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                k_reg <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                k_reg <= k_reg + rlx_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg <= (seed_val == '0) ? rlx_pkg::DEFAULT_SEED : seed_val;
            end
            S_MUL1:
            begin
                prod1_reg <= 64'(x_reg) * 64'(RECIP);
            end
            S_MUL2:
            begin
                qe_reg    <= prod1_reg[63:47];
                prod2_reg <= 33'(prod1_reg[63:47]) * 33'(rlx_pkg::SCH_Q);
            end
            S_CORR:
            begin
                q_reg <= q_fix;
                r_reg <= rem_fix[15:0];
            end
            S_MUL3:
            begin
                t1_reg <= 31'(r_reg) * 31'(rlx_pkg::SCH_A);
                t2_reg <= 31'(q_reg) * 31'(rlx_pkg::SCH_R);
            end
            S_ACC:
            begin
                x_reg <= acc_fix[31:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* sv/rlx_swb.sv */
module rlx_swb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rlx_pkg::cmd_t              cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic                       cfg_we,
    input  logic [rlx_pkg::LUX_W-1:0]  cfg_wdata,
    output logic                       seed_start,
    output logic [rlx_pkg::SEED_W-1:0] seed_val,
    input  rlx_pkg::wr_t               seed_wr,
    input  logic                       seed_done,
    rlx_res_if.source                  res
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SEED = 2'd1;
    localparam logic [1:0] E_DRAW = 2'd2;
    localparam logic [1:0] E_SKIP = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [rlx_pkg::PTR_W-1:0]   long_ptr_reg;
    logic [rlx_pkg::PTR_W-1:0]   long_ptr_next;
    logic [rlx_pkg::PTR_W-1:0]   short_ptr_reg;
    logic [rlx_pkg::PTR_W-1:0]   short_ptr_next;
    logic [rlx_pkg::PTR_W-1:0]   draw_cnt_reg;
    logic [rlx_pkg::PTR_W-1:0]   draw_cnt_next;
    logic                        borrow_reg;
    logic                        borrow_next;
    logic [rlx_pkg::LUX_W-1:0]   luxury_reg;
    logic [rlx_pkg::LUX_W-1:0]   skip_lat_reg;
    logic [rlx_pkg::LUX_W-1:0]   skip_left_reg;
    logic [rlx_pkg::LUX_W-1:0]   skip_left_next;
    logic                        out_valid_reg;
    logic [rlx_pkg::WORD_W-1:0]  value_reg;
    logic [rlx_pkg::LAGS-1:0]    valid_bits_reg;
    logic                        rd_ok_long_reg;
    logic                        rd_ok_short_reg;

    logic [rlx_pkg::WORD_W-1:0]  rd_long_raw;
    logic [rlx_pkg::WORD_W-1:0]  rd_short_raw;
    logic [rlx_pkg::WORD_W-1:0]  rd_long;
    logic [rlx_pkg::WORD_W-1:0]  rd_short;
    logic [rlx_pkg::WORD_W:0]    sub_b;
    logic [rlx_pkg::WORD_W+1:0]  diff;
    logic [rlx_pkg::WORD_W-1:0]  upd_word;
    logic                        updating;
    logic                        out_free;
    rlx_pkg::wr_t                ram_wr;

    // table entries never written since reset read as zero
    assign rd_long  = rd_ok_long_reg  ? rd_long_raw  : '0;
    assign rd_short = rd_ok_short_reg ? rd_short_raw : '0;
    assign sub_b    = (rlx_pkg::WORD_W+1)'(rd_long) + (rlx_pkg::WORD_W+1)'(borrow_reg);
    assign diff     = (rlx_pkg::WORD_W+2)'(rd_short) - (rlx_pkg::WORD_W+2)'(sub_b);
    assign upd_word = diff[rlx_pkg::WORD_W-1:0];

    assign updating   = (state_reg == E_DRAW) || (state_reg == E_SKIP);
    assign out_free   = !out_valid_reg || res.ready;
    assign seed_start = (state_reg == E_IDLE) && cmd_valid && cmd.is_seed;
    assign seed_val   = cmd.seed;
    assign cmd_ready  = (state_reg == E_IDLE) && cmd_valid && (cmd.is_seed || out_free);

    assign res.valid = out_valid_reg;
    assign res.value = value_reg;

    always_comb
    begin
        if (updating)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = long_ptr_reg;
            ram_wr.data = upd_word;
        end
        else
        begin
            ram_wr = seed_wr;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        long_ptr_next  = long_ptr_reg;
        short_ptr_next = short_ptr_reg;
        draw_cnt_next  = draw_cnt_reg;
        borrow_next    = borrow_reg;
        skip_left_next = skip_left_reg;
        if (updating)
        begin
            borrow_next    = diff[rlx_pkg::WORD_W+1];
            long_ptr_next  = (long_ptr_reg == '0) ? rlx_pkg::LAST_LAG
                                                  : long_ptr_reg - rlx_pkg::PTR_W'(1);
            short_ptr_next = (short_ptr_reg == '0) ? rlx_pkg::LAST_LAG
                                                   : short_ptr_reg - rlx_pkg::PTR_W'(1);
        end
        case (state_reg)
            E_IDLE:
            begin
                if (cmd_ready)
                begin
                    state_next = cmd.is_seed ? E_SEED : E_DRAW;
                end
            end
            E_SEED:
            begin
                if (seed_done)
                begin
                    state_next     = E_IDLE;
                    long_ptr_next  = rlx_pkg::LONG_PTR_INIT;
                    short_ptr_next = rlx_pkg::SHORT_PTR_INIT;
                    draw_cnt_next  = '0;
                    borrow_next    = 1'b0;
                end
            end
            E_DRAW:
            begin
                state_next    = E_IDLE;
                draw_cnt_next = draw_cnt_reg + rlx_pkg::PTR_W'(1);
                if (draw_cnt_reg == rlx_pkg::LAST_LAG)
                begin
                    draw_cnt_next = '0;
                    if (skip_lat_reg != '0)
                    begin
                        state_next     = E_SKIP;
                        skip_left_next = skip_lat_reg;
                    end
                end
            end
            E_SKIP:
            begin
                skip_left_next = skip_left_reg - rlx_pkg::LUX_W'(1);
                if (skip_left_reg == rlx_pkg::LUX_W'(1))
                begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // reads are issued at the next pointers, so the registered read data matches the current pointers
    rlx_ram #(
        .WIDTH (rlx_pkg::WORD_W),
        .DEPTH (rlx_pkg::LAGS)
    ) u_table (
        .clk     (clk),
        .we      (ram_wr.en),
        .waddr   (ram_wr.addr),
        .wdata   (ram_wr.data),
        .raddr_a (long_ptr_next),
        .raddr_b (short_ptr_next),
        .rdata_a (rd_long_raw),
        .rdata_b (rd_short_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= E_IDLE;
            long_ptr_reg    <= rlx_pkg::LONG_PTR_INIT;
            short_ptr_reg   <= rlx_pkg::SHORT_PTR_INIT;
            draw_cnt_reg    <= '0;
            borrow_reg      <= 1'b0;
            luxury_reg      <= rlx_pkg::LUX_RESET;
            skip_lat_reg    <= rlx_pkg::skip_from(rlx_pkg::LUX_RESET);
            skip_left_reg   <= '0;
            out_valid_reg   <= 1'b0;
            valid_bits_reg  <= '0;
            rd_ok_long_reg  <= 1'b0;
            rd_ok_short_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            long_ptr_reg  <= long_ptr_next;
            short_ptr_reg <= short_ptr_next;
            draw_cnt_reg  <= draw_cnt_next;
            borrow_reg    <= borrow_next;
            skip_left_reg <= skip_left_next;
            if (cfg_we)
            begin
                luxury_reg <= cfg_wdata;
            end
            if ((state_reg == E_SEED) && seed_done)
            begin
                skip_lat_reg <= rlx_pkg::skip_from(luxury_reg);
            end
            if (state_reg == E_DRAW)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_wr.en)
            begin
                valid_bits_reg[ram_wr.addr] <= 1'b1;
            end
            rd_ok_long_reg  <= valid_bits_reg[long_ptr_next];
            rd_ok_short_reg <= valid_bits_reg[short_ptr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_DRAW)
        begin
            value_reg <= upd_word;
        end
    end

    a_seed_wr_only_seeding: assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr.en |-> (state_reg == E_SEED))
        else $error("seed write outside seeding");

    a_beat_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == E_DRAW))
        else $error("result beat without a draw");

    a_lag_distance: assert property (@(posedge clk) disable iff (!rst_n)
        ((long_ptr_reg >= 5'd14) && (short_ptr_reg == long_ptr_reg - 5'd14)) ||
        ((long_ptr_reg < 5'd14) && (short_ptr_reg == long_ptr_reg + 5'd10)))
        else $error("short and long lag pointers out of step");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_SKIP) |-> (skip_left_reg != '0))
        else $error("discard run with zero count");

    a_no_draw_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_DRAW) |-> !out_valid_reg)
        else $error("draw while result register still full");

endmodule

/* sv/ranlux24_luxury_generator_top.sv */
// channel  dir  beat fields                  handshake
// req      in   req_type[0], seed[31:0]      req.valid / req.ready
// res      out  value[23:0]                  res.valid / res.ready
// cfg      in   cfg_wdata[10:0] (luxury)     cfg_we, no ready
//
// A draw is one update-engine step (E_DRAW); every 24th draw adds luxury-24 table updates
// (none below luxury 24), one per E_SKIP step.
// A seed runs 24 Schrage steps, each through MUL1, MUL2, CORR, MUL3 and ACC in one multiplier chain.
// Reset: table reads as zero until written (24 valid bits), no clearing pass.
// A 2-deep request queue keeps req accepting while the engine works or res stalls, until it is full.
module ranlux24_luxury_generator_top (
    input  logic                      clk,
    input  logic                      rst_n,
    rlx_req_if.sink                   req,
    rlx_res_if.source                 res,
    input  logic                      cfg_we,
    input  logic [rlx_pkg::LUX_W-1:0] cfg_wdata
);

    rlx_pkg::cmd_t                cmd;
    logic                         cmd_valid;
    logic                         cmd_ready;
    logic                         seed_start;
    logic [rlx_pkg::SEED_W-1:0]   seed_val;
    rlx_pkg::wr_t                 seed_wr;
    logic                         seed_done;

    rlx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    rlx_seed u_seed (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (seed_start),
        .seed_val (seed_val),
        .wr       (seed_wr),
        .done     (seed_done)
    );

    rlx_swb u_swb (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .seed_start (seed_start),
        .seed_val   (seed_val),
        .seed_wr    (seed_wr),
        .seed_done  (seed_done),
        .res        (res)
    );

endmodule
